// ===== rtl/core/imuca_pkg.sv =====
// Shared types, constants and tables of the IMU attitude estimator.
package imuca_pkg;

  localparam int CORDIC_STEPS = 14;
  localparam int SUM_WIDTH    = 32;
  localparam int ANG_LIM      = 23040;
  localparam int ANG_TURN     = 46080;
  localparam int INV_GAIN     = 39797;
  localparam int WRAP_STEPS   = 5;
  localparam int CNT_W        = 5;
  localparam int CW           = 28;  // CORDIC x/y width
  localparam int ZW           = 26;  // CORDIC angle width, 2^-16 degree

  typedef enum logic [1:0] {
    CFG_CAL_LOG2 = 2'd0,
    CFG_ALPHA    = 2'd1,
    CFG_ONE_G    = 2'd2,
    CFG_GAIN     = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_CALCHK, S_C1INIT, S_C1, S_MAG, S_C2INIT, S_C2,
    S_PANG, S_FMUL, S_FADD, S_YAW, S_WRAP, S_DONE
  } state_t;

  typedef struct packed {
    logic             load;
    logic             clr_sums;
    logic             cal_acc;
    logic             cal_fin;
    logic             corr;
    logic             c_init;
    logic             c_iter;
    logic             c_sel;
    logic             mag;
    logic             pang;
    logic             fmul;
    logic             fadd;
    logic             f_sel;
    logic             yaw_add;
    logic             wrap;
    logic             load_out;
    logic [CNT_W-1:0] cnt;
  } cmd_t;

  typedef struct packed {
    logic op;
    logic cal;
    logic cal_end;
    logic out_free;
  } status_t;

  // atan(2^-i) in 2^-16 degree
  function automatic logic signed [ZW-1:0] atan_val(input logic [CNT_W-1:0] i);
    logic signed [ZW-1:0] v;
    unique case (i)
      5'd0:  v = ZW'(2949120);
      5'd1:  v = ZW'(1740967);
      5'd2:  v = ZW'(919879);
      5'd3:  v = ZW'(466945);
      5'd4:  v = ZW'(234379);
      5'd5:  v = ZW'(117304);
      5'd6:  v = ZW'(58666);
      5'd7:  v = ZW'(29335);
      5'd8:  v = ZW'(14668);
      5'd9:  v = ZW'(7334);
      5'd10: v = ZW'(3667);
      5'd11: v = ZW'(1833);
      5'd12: v = ZW'(917);
      5'd13: v = ZW'(458);
      5'd14: v = ZW'(229);
      5'd15: v = ZW'(115);
      5'd16: v = ZW'(57);
      5'd17: v = ZW'(29);
      5'd18: v = ZW'(14);
      5'd19: v = ZW'(7);
      5'd20: v = ZW'(4);
      5'd21: v = ZW'(2);
      5'd22: v = ZW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/imu_complementary_attitude.sv =====
// Top level of the six-axis complementary-filter attitude estimator.
// Each sample beat runs offset correction, a 14-step CORDIC pass for roll, gain
// removal, a 14-step pass for pitch, the filter, yaw add, a 5-step wrap and any
// wait for the output to be free before its result beat is registered. No new
// sample is taken before that; calibration and restart beats give no result.
// Reset (synchronous, rst_n low): registers to defaults, calibration restarts.
module imu_complementary_attitude (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_op,
  input  logic signed [15:0] in_accel_x,
  input  logic signed [15:0] in_accel_y,
  input  logic signed [15:0] in_accel_z,
  input  logic signed [15:0] in_gyro_x,
  input  logic signed [15:0] in_gyro_y,
  input  logic signed [15:0] in_gyro_z,
  input  logic [11:0]        in_elapsed_ms,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [16:0] out_accel_x_corr,
  output logic signed [16:0] out_accel_y_corr,
  output logic signed [16:0] out_accel_z_corr,
  output logic signed [16:0] out_gyro_x_corr,
  output logic signed [16:0] out_gyro_y_corr,
  output logic signed [16:0] out_gyro_z_corr,
  output logic signed [15:0] out_roll_angle,
  output logic signed [15:0] out_pitch_angle,
  output logic signed [15:0] out_yaw_angle
);
  import imuca_pkg::*;

  cmd_t    cmd;
  status_t st;

  // register writes are always accepted
  assign cfg_ready = 1'b1;

  imuca_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  imuca_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .st               (st),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_op            (in_op),
    .in_accel_x       (in_accel_x),
    .in_accel_y       (in_accel_y),
    .in_accel_z       (in_accel_z),
    .in_gyro_x        (in_gyro_x),
    .in_gyro_y        (in_gyro_y),
    .in_gyro_z        (in_gyro_z),
    .in_elapsed_ms    (in_elapsed_ms),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_accel_x_corr (out_accel_x_corr),
    .out_accel_y_corr (out_accel_y_corr),
    .out_accel_z_corr (out_accel_z_corr),
    .out_gyro_x_corr  (out_gyro_x_corr),
    .out_gyro_y_corr  (out_gyro_y_corr),
    .out_gyro_z_corr  (out_gyro_z_corr),
    .out_roll_angle   (out_roll_angle),
    .out_pitch_angle  (out_pitch_angle),
    .out_yaw_angle    (out_yaw_angle)
  );

endmodule

// ===== rtl/core/imuca_ctrl.sv =====
// Sequencer of the attitude estimator: steps the datapath through one sample.
module imuca_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  imuca_pkg::status_t st,
  output imuca_pkg::cmd_t    cmd
);
  import imuca_pkg::*;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             fsel_r, fsel_nxt;

  // state, iteration counter and fuse axis select
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      fsel_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      fsel_r  <= fsel_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    fsel_nxt  = fsel_r;
    cmd       = '0;
    cmd.cnt   = cnt_r;
    cmd.f_sel = fsel_r;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        priority if (st.op) begin
          cmd.clr_sums = 1'b1;
          state_nxt    = S_IDLE;
        end else if (st.cal) begin
          cmd.cal_acc = 1'b1;
          state_nxt   = S_CALCHK;
        end else begin
          cmd.corr  = 1'b1;
          state_nxt = S_C1INIT;
        end
      end
      S_CALCHK: begin
        cmd.cal_fin = st.cal_end;
        state_nxt   = S_IDLE;
      end
      S_C1INIT, S_C2INIT: begin
        cmd.c_init = 1'b1;
        cmd.c_sel  = (state_r == S_C2INIT);
        cnt_nxt    = '0;
        state_nxt  = (state_r == S_C2INIT) ? S_C2 : S_C1;
      end
      S_C1, S_C2: begin
        cmd.c_iter = 1'b1;
        if (cnt_r == CNT_W'(CORDIC_STEPS - 1)) begin
          state_nxt = (state_r == S_C2) ? S_PANG : S_MAG;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_MAG: begin
        cmd.mag   = 1'b1;
        state_nxt = S_C2INIT;
      end
      S_PANG: begin
        cmd.pang  = 1'b1;
        fsel_nxt  = 1'b0;
        state_nxt = S_FMUL;
      end
      S_FMUL: begin
        cmd.fmul  = 1'b1;
        state_nxt = S_FADD;
      end
      S_FADD: begin
        cmd.fadd = 1'b1;
        if (fsel_r) begin
          state_nxt = S_YAW;
        end else begin
          fsel_nxt  = 1'b1;
          state_nxt = S_FMUL;
        end
      end
      S_YAW: begin
        cmd.yaw_add = 1'b1;
        cnt_nxt     = CNT_W'(WRAP_STEPS - 1);
        state_nxt   = S_WRAP;
      end
      S_WRAP: begin
        cmd.wrap = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/imuca_dp.sv =====
// Datapath: calibration sums, offsets, CORDIC, filter and yaw integration.
module imuca_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  imuca_pkg::cmd_t     cmd,
  output imuca_pkg::status_t  st,
  input  logic                cfg_valid,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic                in_op,
  input  logic signed [15:0]  in_accel_x,
  input  logic signed [15:0]  in_accel_y,
  input  logic signed [15:0]  in_accel_z,
  input  logic signed [15:0]  in_gyro_x,
  input  logic signed [15:0]  in_gyro_y,
  input  logic signed [15:0]  in_gyro_z,
  input  logic [11:0]         in_elapsed_ms,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [16:0]  out_accel_x_corr,
  output logic signed [16:0]  out_accel_y_corr,
  output logic signed [16:0]  out_accel_z_corr,
  output logic signed [16:0]  out_gyro_x_corr,
  output logic signed [16:0]  out_gyro_y_corr,
  output logic signed [16:0]  out_gyro_z_corr,
  output logic signed [15:0]  out_roll_angle,
  output logic signed [15:0]  out_pitch_angle,
  output logic signed [15:0]  out_yaw_angle
);
  import imuca_pkg::*;

  localparam int AW = SUM_WIDTH + 2;  // rounding average width
  localparam int DW = 46;             // gyro delta, 2^-24 units
  localparam int HW = DW - 24;
  localparam int SW = 66;             // filter sum, 2^-40 units
  localparam int YW = 24;

  function automatic logic signed [15:0] to_units(input logic signed [ZW-1:0] z);
    logic signed [ZW-1:0] t;
    t = (z + ZW'(256)) >>> 9;
    if (t > ZW'(ANG_LIM)) t = ZW'(ANG_LIM);
    else if (t < -ZW'(ANG_LIM)) t = -ZW'(ANG_LIM);
    return t[15:0];
  endfunction

  logic [3:0]  cal_log2_r;
  logic [15:0] alpha_r;
  logic [14:0] one_g_r;
  logic [15:0] gain_r;

  logic                  op_r;
  logic signed [15:0]    raw_r [6];
  logic [11:0]           ems_r;
  logic                  cal_r;
  logic [15:0]           count_r;
  logic [SUM_WIDTH-1:0]  sum_r [6];
  logic signed [16:0]    off_r [6];
  logic signed [16:0]    off_nxt [6];
  logic signed [16:0]    corr_r [6];
  logic signed [16:0]    corr_nxt [6];
  logic [27:0]           d_r;

  logic signed [CW-1:0]  cx_r, cy_r;
  logic signed [ZW-1:0]  cz_r;
  logic                  zero_r;
  logic signed [CW-1:0]  mag2_r;
  logic signed [15:0]    acc_roll_r, acc_pitch_r;
  logic signed [DW-1:0]  dr_r, dp_r, dy_r;
  logic signed [32:0]    p1_r;
  logic signed [33:0]    p2_r;
  logic signed [38:0]    p3_r;
  logic [39:0]           p4_r;
  logic signed [15:0]    roll_r, pitch_r, yaw_r;
  logic signed [YW-1:0]  yw_r;
  logic                  out_valid_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_log2_r <= 4'd10;
      alpha_r    <= 16'd62915;
      one_g_r    <= 15'd16384;
      gain_r     <= 16'd16393;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_CAL_LOG2: cal_log2_r <= cfg_data[3:0];
        CFG_ALPHA:    alpha_r    <= cfg_data;
        CFG_ONE_G:    one_g_r    <= cfg_data[14:0];
        CFG_GAIN:     gain_r     <= cfg_data;
      endcase
    end
  end

  // input beat capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= in_op;
      raw_r[0] <= in_accel_x;
      raw_r[1] <= in_accel_y;
      raw_r[2] <= in_accel_z;
      raw_r[3] <= in_gyro_x;
      raw_r[4] <= in_gyro_y;
      raw_r[5] <= in_gyro_z;
      ems_r    <= in_elapsed_ms;
    end
  end

  // offset rounding and saturation, corrected values
  always_comb begin
    logic signed [AW-1:0] s, rnd, avg;
    logic signed [17:0]   diff;
    for (int i = 0; i < 6; i++) begin
      s   = AW'($signed(sum_r[i]));
      rnd = (cal_log2_r == 4'd0) ? '0 : (AW'(1) <<< (cal_log2_r - 4'd1));
      avg = (s + rnd) >>> cal_log2_r;
      if (i == 2) avg = avg - AW'($signed({1'b0, one_g_r}));
      if (avg > AW'(65535)) off_nxt[i] = 17'sd65535;
      else if (avg < -AW'(65536)) off_nxt[i] = -17'sd65536;
      else off_nxt[i] = avg[16:0];
      diff = 18'(raw_r[i]) - 18'(off_r[i]);
      if (diff > 18'sd65535) corr_nxt[i] = 17'sd65535;
      else if (diff < -18'sd65536) corr_nxt[i] = -17'sd65536;
      else corr_nxt[i] = diff[16:0];
    end
  end

  // calibration state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r   <= 1'b1;
      count_r <= '0;
      for (int i = 0; i < 6; i++) begin
        sum_r[i] <= '0;
        off_r[i] <= '0;
      end
    end else begin
      if (cmd.clr_sums) begin
        cal_r   <= 1'b1;
        count_r <= '0;
        for (int i = 0; i < 6; i++) sum_r[i] <= '0;
      end
      if (cmd.cal_acc) begin
        count_r <= count_r + 16'd1;
        for (int i = 0; i < 6; i++)
          sum_r[i] <= sum_r[i] + {{(SUM_WIDTH-16){raw_r[i][15]}}, raw_r[i]};
      end
      if (cmd.cal_fin) begin
        cal_r <= 1'b0;
        for (int i = 0; i < 6; i++) off_r[i] <= off_nxt[i];
      end
    end
  end

  // corrected values and time step product
  always_ff @(posedge clk) begin
    if (cmd.corr) begin
      for (int i = 0; i < 6; i++) corr_r[i] <= corr_nxt[i];
      d_r <= ems_r * gain_r;
    end
  end

  // vectoring CORDIC, one rotation per cycle
  always_ff @(posedge clk) begin
    logic signed [CW-1:0] x0, y0, xs, ys;
    x0 = cmd.c_sel ? mag2_r : {{(CW-25){corr_r[2][16]}}, corr_r[2], 8'd0};
    y0 = cmd.c_sel ? -{{(CW-25){corr_r[0][16]}}, corr_r[0], 8'd0}
                   :  {{(CW-25){corr_r[1][16]}}, corr_r[1], 8'd0};
    xs = cx_r >>> cmd.cnt;
    ys = cy_r >>> cmd.cnt;
    if (cmd.c_init) begin
      zero_r <= (x0 == '0) && (y0 == '0);
      priority if (x0 < 0 && y0 >= 0) begin
        cx_r <= y0;
        cy_r <= -x0;
        cz_r <= ZW'(90 * 65536);
      end else if (x0 < 0) begin
        cx_r <= -y0;
        cy_r <= x0;
        cz_r <= -ZW'(90 * 65536);
      end else begin
        cx_r <= x0;
        cy_r <= y0;
        cz_r <= '0;
      end
    end else if (cmd.c_iter && !zero_r) begin
      if (cy_r > 0) begin
        cx_r <= cx_r + ys;
        cy_r <= cy_r - xs;
        cz_r <= cz_r + atan_val(cmd.cnt);
      end else begin
        cx_r <= cx_r - ys;
        cy_r <= cy_r + xs;
        cz_r <= cz_r - atan_val(cmd.cnt);
      end
    end
  end

  // gain removal, accel angles and gyro deltas
  always_ff @(posedge clk) begin
    logic signed [CW+16:0] mp;
    logic signed [DW-1:0]  pr, pp, py;
    mp = cx_r * $signed({1'b0, 16'(INV_GAIN)});
    pr = corr_r[3] * $signed({1'b0, d_r});
    pp = corr_r[4] * $signed({1'b0, d_r});
    py = corr_r[5] * $signed({1'b0, d_r});
    if (cmd.mag) begin
      mag2_r     <= mp[CW+15:16];
      acc_roll_r <= to_units(cz_r);
    end
    if (cmd.pang) begin
      acc_pitch_r <= to_units(cz_r);
      dr_r <= pr;
      dp_r <= pp;
      dy_r <= py;
    end
  end

  // complementary filter partial products, one axis per pass
  always_ff @(posedge clk) begin
    logic signed [15:0]   old, acc;
    logic signed [DW-1:0] dl;
    logic signed [HW-1:0] dhi;
    logic [16:0]          na;
    old = cmd.f_sel ? pitch_r : roll_r;
    acc = cmd.f_sel ? acc_pitch_r : acc_roll_r;
    dl  = cmd.f_sel ? dp_r : dr_r;
    dhi = HW'(dl >>> 24);
    na  = 17'd65536 - {1'b0, alpha_r};
    if (cmd.fmul) begin
      p1_r <= $signed({1'b0, alpha_r}) * old;
      p2_r <= $signed({1'b0, na}) * acc;
      p3_r <= $signed({1'b0, alpha_r}) * dhi;
      p4_r <= alpha_r * dl[23:0];
    end
  end

  // filter sum, rounding and saturation; yaw integration and wrap
  always_ff @(posedge clk) begin
    logic signed [SW-1:0] h, s, r;
    logic signed [15:0]   f;
    logic signed [DW-1:0] yd;
    logic signed [YW-1:0] m;
    h  = SW'(p1_r) + SW'(p2_r) + SW'(p3_r);
    s  = (h <<< 24) + $signed({{(SW-40){1'b0}}, p4_r}) + (SW'(1) <<< 39);
    r  = s >>> 40;
    if (r > SW'(ANG_LIM)) f = 16'(ANG_LIM);
    else if (r < -SW'(ANG_LIM)) f = -16'(ANG_LIM);
    else f = r[15:0];
    yd = (dy_r + (DW'(1) <<< 23)) >>> 24;
    m  = YW'(ANG_TURN) <<< cmd.cnt;
    if (!rst_n) begin
      roll_r  <= '0;
      pitch_r <= '0;
      yaw_r   <= '0;
    end else begin
      if (cmd.fadd) begin
        if (cmd.f_sel) pitch_r <= f;
        else roll_r <= f;
      end
      if (cmd.load_out) yaw_r <= yw_r[15:0];
    end
    if (cmd.yaw_add) yw_r <= YW'(yaw_r) + YW'(yd);
    else if (cmd.wrap) begin
      if (yw_r > 0) begin
        if (yw_r - m > -YW'(ANG_LIM)) yw_r <= yw_r - m;
      end else begin
        if (yw_r + m < YW'(ANG_LIM)) yw_r <= yw_r + m;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.load_out) begin
      out_accel_x_corr <= corr_r[0];
      out_accel_y_corr <= corr_r[1];
      out_accel_z_corr <= corr_r[2];
      out_gyro_x_corr  <= corr_r[3];
      out_gyro_y_corr  <= corr_r[4];
      out_gyro_z_corr  <= corr_r[5];
      out_roll_angle   <= roll_r;
      out_pitch_angle  <= pitch_r;
      out_yaw_angle    <= yw_r[15:0];
    end
  end

  assign out_valid   = out_valid_r;
  assign st.op       = op_r;
  assign st.cal      = cal_r;
  assign st.cal_end  = {1'b0, count_r} >= (17'd1 << cal_log2_r);
  assign st.out_free = !out_valid_r || out_ready;

  // checks
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result overwritten before taken");
  a_out_set: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid_r)
    else $error("result beat not presented");
  a_fin_in_cal: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cal_fin |-> cal_r)
    else $error("offsets learned outside calibration");
  a_zero_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.c_iter && zero_r) |=> (cx_r == '0 && cz_r == '0))
    else $error("zero vector rotated");

endmodule
